// File: sv/ilie_pkg.sv
// Shared types and constants for the indexed list with insert and erase.
package ilie_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_ERASE  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast from the request decoder to every cell of the row.
    typedef struct packed {
        logic              ins;
        logic              ers;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } ilie_ctl_t;

endpackage

// File: sv/ilie_cell.sv
// One element cell of the shifting row: holds one entry and trades with its neighbors.
module ilie_cell
    import ilie_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic              clk,
    input  ilie_ctl_t         ctl,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    output logic [DATA_W-1:0] val,
    output logic [DATA_W-1:0] rd_val
);

    localparam int PW = ($clog2(POS + 2) > IDX_W) ? $clog2(POS + 2) : IDX_W;
    localparam logic [PW-1:0] POS_V = PW'(POS);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [PW-1:0]     idx_ext;
    logic              hit;
    logic              above;

    assign idx_ext = PW'(ctl.idx);
    assign hit     = (POS_V == idx_ext);
    assign above   = (POS_V > idx_ext);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.ins)
        begin
            // Cells above the insertion point take their lower neighbor's entry.
            if (above)
            begin
                value_next = left_val;
            end
            else if (hit)
            begin
                value_next = ctl.val;
            end
        end
        else if (ctl.ers)
        begin
            if (above || hit)
            begin
                value_next = right_val;
            end
        end
        else if (ctl.wr && hit)
        begin
            value_next = ctl.val;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign val    = value_reg;
    assign rd_val = hit ? value_reg : '0;

endmodule

// File: sv/indexed_list_insert_erase.sv
// Indexed list of signed 32-bit elements with read, overwrite, insert and erase by index.
// Each result word is registered when its request word is accepted and appears in the next cycle.
// Throughput: one request per cycle while results are taken; the row of cells shifts the whole list at once.
// The output register lets a new request in while the previous result is being taken.
// Reset clears the element count and the output valid; cell contents stay undefined.
module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operation[1:0], index[7:2], value[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // read_value[31:0], status[33:32],
                                       // element_count[40:34], is_empty[41], zero pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] cell_rd  [CAPACITY];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;
    status_t           status_reg;
    status_t           status_next;

    logic              accept;
    op_t               op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wval;
    logic [KW-1:0]     idx_k;
    logic [KW-1:0]     count_k;
    logic              in_range;
    logic              ins_range;
    logic              full;
    logic [DATA_W-1:0] rd_any;
    ilie_ctl_t         ctl;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign op   = op_t'(s_axis_tdata[1:0]);
    assign idx  = s_axis_tdata[7:2];
    assign wval = s_axis_tdata[39:8];

    assign idx_k     = KW'(idx);
    assign count_k   = KW'(count_reg);
    assign in_range  = (idx_k < count_k);
    assign ins_range = (idx_k <= count_k);
    assign full      = (count_reg == CAP_V);

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb
    begin
        ctl            = '0;
        ctl.idx        = idx;
        ctl.val        = wval;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        rd_next        = rd_reg;
        status_next    = status_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            rd_next        = '0;
            status_next    = ST_DONE;
            case (op)
                OP_INSERT:
                begin
                    if (!ins_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        rd_next = rd_any;
                    end
                end
                OP_WRITE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctl.wr = 1'b1;
                    end
                end
                OP_ERASE:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctl.ers    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg     <= rd_next;
        status_reg <= status_next;
    end

    // The count register advances together with the result, so the word
    // shows the count left behind by its own request.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_v;
            logic [DATA_W-1:0] right_v;
            if (g == 0)
            begin : g_first
                assign left_v = cell_val[0];
            end
            else
            begin : g_mid_l
                assign left_v = cell_val[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_v = cell_val[g];
            end
            else
            begin : g_mid_r
                assign right_v = cell_val[g+1];
            end
            ilie_cell #(
                .POS (g)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .left_val  (left_v),
                .right_val (right_v),
                .val       (cell_val[g]),
                .rd_val    (cell_rd[g])
            );
        end
    endgenerate

    assign m_axis_tvalid        = out_valid_reg;
    assign m_axis_tdata[31:0]   = rd_reg;
    assign m_axis_tdata[33:32]  = status_reg;
    assign m_axis_tdata[40:34]  = COUNT_W'(count_reg);
    assign m_axis_tdata[41]     = (count_reg == '0);
    assign m_axis_tdata[47:42]  = '0;

endmodule
